// File: design/rrts_pkg.sv
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdW = $clog2(MaxTasks);
  localparam int unsigned CntW = $clog2(MaxTasks + 1);

  localparam logic [15:0] SliceReset = 16'd10;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_YIELD = 2'd1;
  localparam logic [1:0] MODE_SLEEP = 2'd2;
  localparam logic [1:0] MODE_READY = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  task_id;
    logic [31:0] sleep_ticks;
  } rrts_in_t;

  typedef struct packed {
    logic [3:0] active_task;
    logic       idle_running;
    logic       switched;
    logic       accepted;
  } rrts_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic walk;
    logic slice;
    logic op;
    logic disp;
  } rrts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CntW-1:0] sleep_cnt;
  } rrts_stat_t;

endpackage

// File: design/round_robin_task_scheduler_core.sv
`timescale 1ns / 1ps
// a tick runs load, sleep-list walk (one sleeper checked per cycle), slice
// countdown, dispatch; yield, sleep and make-ready run load, op, dispatch
// throughput: one item at a time, next start taken in the strobe cycle
// reset: async active low, idle task runs, queues empty, slice_ticks = 10
// the result strobe lasts one cycle and cannot be stalled by the receiver
module round_robin_task_scheduler_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  rrts_pkg::rrts_in_t  item_i,
  output logic                result_valid_o,
  output rrts_pkg::rrts_out_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import rrts_pkg::*;

  rrts_cmd_t  cmd;
  rrts_stat_t stat;

  // config beat always taken; only written while idle by contract
  assign cfg_ready_o = 1'b1;

  // sequencer: walk of the sleep list, slice countdown, dispatch
  rrts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .mode_i (item_i.mode),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (result_valid_o)
  );

  // queues, countdowns and the result register
  rrts_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .item_i    (item_i),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .stat_o    (stat),
    .res_o     (result_o)
  );

endmodule

// File: design/rrts_ctrl.sv
`timescale 1ns / 1ps
module rrts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          mode_i,
  input  rrts_pkg::rrts_stat_t stat_i,
  output rrts_pkg::rrts_cmd_t  cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SLICE,
    ST_OP,
    ST_DISP
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] walk_left_q, walk_left_d;
  logic            done_q, done_d;
  logic            accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    walk_left_d = walk_left_q;
    done_d      = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (mode_i == MODE_TICK) begin
            walk_left_d = stat_i.sleep_cnt;
            state_d     = ST_WALK;
          end else begin
            state_d = ST_OP;
          end
        end
      end
      ST_WALK: begin
        if (walk_left_q == '0) begin
          state_d = ST_SLICE;
        end else begin
          cmd_o.walk  = 1'b1;
          walk_left_d = walk_left_q - 1'b1;
        end
      end
      ST_SLICE: begin
        cmd_o.slice = 1'b1;
        state_d     = ST_DISP;
      end
      ST_OP: begin
        cmd_o.op = 1'b1;
        state_d  = ST_DISP;
      end
      ST_DISP: begin
        cmd_o.disp = 1'b1;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      walk_left_q <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_left_q <= walk_left_d;
      done_q      <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("accepted item did not raise busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE) else $error("result strobe while busy");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_left_q <= CntW'(MaxTasks)) else $error("walk count out of range");

endmodule

// File: design/rrts_dpath.sv
`timescale 1ns / 1ps
module rrts_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrts_pkg::rrts_cmd_t  cmd_i,
  input  rrts_pkg::rrts_in_t   item_i,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_data_i,
  output rrts_pkg::rrts_stat_t stat_o,
  output rrts_pkg::rrts_out_t  res_o
);
  import rrts_pkg::*;

  rrts_in_t        item_q, item_d;
  logic [15:0]     slice_ticks_q;
  logic [IdW-1:0]  rq_q [MaxTasks];
  logic [IdW-1:0]  rq_d [MaxTasks];
  logic [IdW-1:0]  so_q [MaxTasks];
  logic [IdW-1:0]  so_d [MaxTasks];
  logic [31:0]     sl_q [MaxTasks];
  logic [31:0]     sl_d [MaxTasks];
  logic [15:0]     sc_q [MaxTasks];
  logic [15:0]     sc_d [MaxTasks];
  logic [CntW-1:0] rcnt_q, rcnt_d, scnt_q, scnt_d;
  logic [15:0]     idle_slice_q, idle_slice_d;
  logic [IdW-1:0]  run_q, run_d;
  logic            idle_q, idle_d;
  logic [MaxTasks-1:0] present_q, present_d;
  logic            need_q, need_d, acc_q, acc_d;
  rrts_out_t       res_q, res_d;

  logic [IdW-1:0]  wid, rtail;
  logic            sw;

  always_comb begin
    item_d       = item_q;
    rq_d         = rq_q;
    so_d         = so_q;
    sl_d         = sl_q;
    sc_d         = sc_q;
    rcnt_d       = rcnt_q;
    scnt_d       = scnt_q;
    idle_slice_d = idle_slice_q;
    run_d        = run_q;
    idle_d       = idle_q;
    present_d    = present_q;
    need_d       = need_q;
    acc_d        = acc_q;
    res_d        = res_q;
    sw           = 1'b0;
    wid          = so_q[0];
    rtail        = IdW'(rcnt_q - 1'b1);

    if (cmd_i.load) begin
      item_d = item_i;
      need_d = 1'b0;
      acc_d  = 1'b1;
    end

    // one sleeper a step: pop head, wake it or put it back at the tail
    if (cmd_i.walk) begin
      for (int i = 0; i < MaxTasks - 1; i++) so_d[i] = so_q[i + 1];
      if (sl_q[wid] <= 32'd1) begin
        sl_d[wid] = '0;
        rq_d[IdW'(rcnt_q)] = wid;
        rcnt_d = rcnt_q + 1'b1;
        scnt_d = scnt_q - 1'b1;
      end else begin
        sl_d[wid] = sl_q[wid] - 32'd1;
        so_d[IdW'(scnt_q - 1'b1)] = wid;
      end
    end

    if (cmd_i.slice) begin
      if (idle_q) begin
        if (idle_slice_q <= 16'd1) begin
          idle_slice_d = slice_ticks_q;
          need_d = 1'b1;
        end else begin
          idle_slice_d = idle_slice_q - 16'd1;
        end
      end else if (sc_q[run_q] <= 16'd1) begin
        sc_d[run_q] = slice_ticks_q;
        for (int i = 0; i < MaxTasks - 1; i++) rq_d[i] = rq_q[i + 1];
        rq_d[rtail] = rq_q[0];
        need_d = 1'b1;
      end else begin
        sc_d[run_q] = sc_q[run_q] - 16'd1;
      end
    end

    if (cmd_i.op) begin
      case (item_q.mode)
        MODE_YIELD: begin
          if (rcnt_q > CntW'(1)) begin
            if (!idle_q) begin
              for (int i = 0; i < MaxTasks - 1; i++) rq_d[i] = rq_q[i + 1];
              rq_d[rtail] = rq_q[0];
            end
            need_d = 1'b1;
          end
        end
        MODE_SLEEP: begin
          // running task is always the queue head
          if (!idle_q) begin
            for (int i = 0; i < MaxTasks - 1; i++) rq_d[i] = rq_q[i + 1];
            if (item_q.sleep_ticks == '0) begin
              rq_d[rtail] = run_q;
            end else begin
              rcnt_d = rcnt_q - 1'b1;
              sl_d[run_q] = item_q.sleep_ticks;
              so_d[IdW'(scnt_q)] = run_q;
              scnt_d = scnt_q + 1'b1;
            end
          end
          need_d = 1'b1;
        end
        MODE_READY: begin
          if (present_q[item_q.task_id]) begin
            acc_d = 1'b0;
          end else begin
            present_d[item_q.task_id] = 1'b1;
            sc_d[item_q.task_id] = slice_ticks_q;
            rq_d[IdW'(rcnt_q)] = item_q.task_id;
            rcnt_d = rcnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.disp) begin
      if (need_q) begin
        if (rcnt_q == '0) begin
          sw     = !idle_q;
          idle_d = 1'b1;
        end else begin
          sw     = idle_q || (rq_q[0] != run_q);
          idle_d = 1'b0;
          run_d  = rq_q[0];
        end
      end
      res_d.active_task  = idle_d ? 4'd0 : run_d;
      res_d.idle_running = idle_d;
      res_d.switched     = sw;
      res_d.accepted     = acc_q;
    end
  end

  // payload stores, no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rq_q   <= rq_d;
    so_q   <= so_d;
    sl_q   <= sl_d;
    sc_q   <= sc_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_ticks_q <= SliceReset;
      rcnt_q        <= '0;
      scnt_q        <= '0;
      idle_slice_q  <= SliceReset;
      run_q         <= '0;
      idle_q        <= 1'b1;
      present_q     <= '0;
      need_q        <= 1'b0;
    end else begin
      if (cfg_we_i) slice_ticks_q <= cfg_data_i;
      rcnt_q       <= rcnt_d;
      scnt_q       <= scnt_d;
      idle_slice_q <= idle_slice_d;
      run_q        <= run_d;
      idle_q       <= idle_d;
      present_q    <= present_d;
      need_q       <= need_d;
    end
  end

  assign stat_o.sleep_cnt = scnt_q;
  assign res_o            = res_q;

  // a sleep may empty the queue in the cycle before dispatch catches up
  a_run_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle_q && !cmd_i.disp |-> rcnt_q != '0) else $error("task runs with empty ready queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rcnt_q + scnt_q) <= (CntW + 1)'(MaxTasks)) else $error("task count overflow");

endmodule
